// ----- sv/swrl_pkg.sv -----
// shared constants and codes for the sliding-window request limiter
package swrl_pkg;

    localparam int LOG_DEPTH_DEF = 128;

    localparam int ACTION_W = 2;
    localparam int TIME_W   = 32;
    localparam int SCOUNT_W = 8;
    localparam int LIMIT_W  = 8;
    localparam int WINDOW_W = 16;
    localparam int WAIT_W   = 17;
    localparam int LCOUNT_W = 8;
    localparam int CFG_W    = 16;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 32;

    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 8'd20;
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd1;
    localparam logic [WAIT_W-1:0]   WAIT_MAX   = 17'h1FFFF;

    localparam logic [ACTION_W-1:0] ACT_CHECK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RECORD  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CORRECT = 2'd2;

    localparam logic [0:0] REG_INIT_LIMIT  = 1'b0;
    localparam logic [0:0] REG_INIT_WINDOW = 1'b1;

endpackage

// ----- sv/swrl_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module swrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- sv/sliding_window_request_limiter_core.sv -----
// sliding-window request limiter: timestamp log in ram, expiry, record and server correction
//
// Input words arrive on the s_axis channel: tuser carries the action (check, record,
// correct), tdata carries now, stamp, server count, limit and window. Every input word
// yields exactly one result word on m_axis: wait in seconds, log occupancy, and an
// overflow flag in tuser.
// The timestamp log lives in one ram with a registered read, addressed by the head
// pointer; every pass through it is a read followed by a compare in the next cycle.
// A word passes from idle through the expiry states, the action state, the pad state
// on a correction that pads, and the result states; each expired stamp costs a ram read
// then a compare, and each stamp padded by a correction one ram write. Trimming on a
// correction is done in the action state by moving the head pointer.
// s_axis_tready is high only between words; the next word is taken while the previous
// result still waits in the output register.
// If the receiver stalls, the result holds in the output register and a finished
// word waits in its last state until the register frees.
// Synchronous active-low reset clears the log (head and count to zero, contents left
// as they are), and loads a limit of 20 and a window of 1 second.
// Configuration writes load the active limit or window directly.
module sliding_window_request_limiter_core #(
    parameter int LOG_DEPTH = swrl_pkg::LOG_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // now[31:0], stamp[63:32], server_count[71:64], new_limit[79:72],
    // server_window[95:80]
    input  logic [swrl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // action[1:0]
    input  logic [swrl_pkg::ACTION_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // wait_seconds[16:0], log_count[24:17], zero fill [31:25]
    output logic [swrl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // overflow[0]
    output logic [0:0]                          m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_addr,
    input  logic [swrl_pkg::CFG_W-1:0]          i_cfg_wdata
);

    localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int KW = (CW > swrl_pkg::SCOUNT_W) ? CW : swrl_pkg::SCOUNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(LOG_DEPTH);
    localparam logic [KW-1:0] DEPTH_K = KW'(LOG_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXP_RD,
        S_EXP,
        S_ACT,
        S_PAD,
        S_RES_RD,
        S_RES
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]                    r_head, n_head;
    logic [CW-1:0]                    r_count, n_count;
    logic [swrl_pkg::LIMIT_W-1:0]     r_limit, n_limit;
    logic [swrl_pkg::WINDOW_W-1:0]    r_window, n_window;
    logic                             r_ovf, n_ovf;
    logic                             r_out_valid, n_out_valid;

    logic [swrl_pkg::ACTION_W-1:0]    r_action, n_action;
    logic [swrl_pkg::TIME_W-1:0]      r_now, n_now;
    logic [swrl_pkg::TIME_W-1:0]      r_stamp, n_stamp;
    logic [swrl_pkg::SCOUNT_W-1:0]    r_scount, n_scount;
    logic [swrl_pkg::LIMIT_W-1:0]     r_slimit, n_slimit;
    logic [swrl_pkg::WINDOW_W-1:0]    r_swindow, n_swindow;
    logic [swrl_pkg::WAIT_W-1:0]      r_out_wait, n_out_wait;
    logic [swrl_pkg::LCOUNT_W-1:0]    r_out_count, n_out_count;
    logic                             r_out_ovf, n_out_ovf;

    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    logic [swrl_pkg::TIME_W-1:0]      mem_wdata;
    logic [swrl_pkg::TIME_W-1:0]      mem_rdata;

    logic [KW-1:0]                    count_k;
    logic [KW-1:0]                    scount_k;
    logic [KW-1:0]                    limit_k;
    logic signed [33:0]               age;
    logic signed [33:0]               age_res;
    logic signed [35:0]               dly;
    logic                             expire;
    logic                             in_acc;
    logic [CW-1:0]                    pad_cnt;
    logic [swrl_pkg::WAIT_W-1:0]      wait_sat;

    // head plus offset, wrapped once; sum stays below twice the depth
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(LOG_DEPTH)) begin
            s = s - (CW+1)'(LOG_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    swrl_ram #(
        .WIDTH (swrl_pkg::TIME_W),
        .DEPTH (LOG_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_head),
        .o_rdata (mem_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_count, r_out_wait};
    assign m_axis_tuser  = r_out_ovf;

    assign count_k  = KW'(r_count);
    assign scount_k = KW'(r_scount);
    assign limit_k  = KW'(r_limit);

    // signed age of the oldest stamp, negative when the stamp lies ahead of now
    assign age     = $signed({2'b00, r_now}) - $signed({2'b00, mem_rdata});
    assign expire  = (r_count != '0) && (age > $signed({18'b0, r_window}));
    assign age_res = (r_count != '0) ? age : 34'sd0;
    assign dly     = $signed({20'b0, r_window}) + $signed(36'd1)
                   - $signed({{2{age_res[33]}}, age_res});

    always_comb begin
        if (dly < 36'sd0) begin
            wait_sat = '0;
        end else if (dly > $signed({19'b0, swrl_pkg::WAIT_MAX})) begin
            wait_sat = swrl_pkg::WAIT_MAX;
        end else begin
            wait_sat = dly[swrl_pkg::WAIT_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_limit     = r_limit;
        n_window    = r_window;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_action    = r_action;
        n_now       = r_now;
        n_stamp     = r_stamp;
        n_scount    = r_scount;
        n_slimit    = r_slimit;
        n_swindow   = r_swindow;
        n_out_wait  = r_out_wait;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;
        mem_we      = 1'b0;
        mem_waddr   = wrap_add(r_head, r_count);
        mem_wdata   = r_stamp;
        pad_cnt     = r_count;

        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                swrl_pkg::REG_INIT_LIMIT: begin
                    n_limit = i_cfg_wdata[swrl_pkg::LIMIT_W-1:0];
                end
                swrl_pkg::REG_INIT_WINDOW: begin
                    n_window = i_cfg_wdata[swrl_pkg::WINDOW_W-1:0];
                end
                default: begin
                    n_window = r_window;
                end
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_action  = s_axis_tuser;
                    n_now     = s_axis_tdata[31:0];
                    n_stamp   = s_axis_tdata[63:32];
                    n_scount  = s_axis_tdata[71:64];
                    n_slimit  = s_axis_tdata[79:72];
                    n_swindow = s_axis_tdata[95:80];
                    n_ovf     = 1'b0;
                    // ram already reads the head entry this cycle
                    n_state   = S_EXP;
                end
            end
            S_EXP_RD: begin
                n_state = S_EXP;
            end
            S_EXP: begin
                if (expire) begin
                    n_head  = wrap_add(r_head, CW'(1));
                    n_count = r_count - CW'(1);
                    n_state = S_EXP_RD;
                end else begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_state = S_RES_RD;
                unique case (r_action)
                    swrl_pkg::ACT_RECORD: begin
                        mem_we = 1'b1;
                        // a full log overwrites its oldest slot
                        if (r_count == DEPTH_C) begin
                            n_head = wrap_add(r_head, CW'(1));
                            n_ovf  = 1'b1;
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                    end
                    swrl_pkg::ACT_CORRECT: begin
                        n_limit  = r_slimit;
                        n_window = r_swindow;
                        if (count_k > scount_k) begin
                            n_head  = wrap_add(r_head, CW'(count_k - scount_k));
                            n_count = CW'(scount_k);
                        end else if (count_k < scount_k) begin
                            n_state = S_PAD;
                        end
                    end
                    default: begin
                        n_state = S_RES_RD;
                    end
                endcase
            end
            S_PAD: begin
                mem_we    = 1'b1;
                mem_wdata = r_now;
                if (r_count == DEPTH_C) begin
                    n_head  = wrap_add(r_head, CW'(1));
                    n_ovf   = 1'b1;
                    pad_cnt = r_count;
                end else begin
                    pad_cnt = r_count + CW'(1);
                end
                n_count = pad_cnt;
                // stop at the wanted count, or once full when more was asked for
                if ((KW'(pad_cnt) >= scount_k)
                    || ((pad_cnt == DEPTH_C) && (scount_k > DEPTH_K))) begin
                    n_state = S_RES_RD;
                end
            end
            S_RES_RD: begin
                n_state = S_RES;
            end
            S_RES: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_wait  = (count_k >= limit_k) ? wait_sat : '0;
                    n_out_count = count_k[swrl_pkg::LCOUNT_W-1:0];
                    n_out_ovf   = r_ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_limit     <= swrl_pkg::LIMIT_RST;
            r_window    <= swrl_pkg::WINDOW_RST;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_limit     <= n_limit;
            r_window    <= n_window;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_action    <= n_action;
        r_now       <= n_now;
        r_stamp     <= n_stamp;
        r_scount    <= n_scount;
        r_slimit    <= n_slimit;
        r_swindow   <= n_swindow;
        r_out_wait  <= n_out_wait;
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (KW'(r_count) <= DEPTH_K) && ((CW+1)'(r_head) < (CW+1)'(LOG_DEPTH)))
        else $error("log count or head pointer out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES && r_ovf) |-> (r_count == DEPTH_C))
        else $error("overflow reported on a log that is not full");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD) |-> (count_k < scount_k))
        else $error("padding with the log already at the wanted count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP && expire) |=> (r_state == S_EXP_RD))
        else $error("expiry compare not followed by a fresh head read");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> r_out_valid && $stable(r_out_wait))
        else $error("stalled result changed");

endmodule

// ----- tb/tb_sliding_window_request_limiter_core.sv -----
// testbench for the sliding-window request limiter: directed table, random words, self-checking
module tb_sliding_window_request_limiter_core;

    localparam int DEPTH      = swrl_pkg::LOG_DEPTH_DEF;
    localparam int ACTION_W   = swrl_pkg::ACTION_W;
    localparam int TIME_W     = swrl_pkg::TIME_W;
    localparam int SCOUNT_W   = swrl_pkg::SCOUNT_W;
    localparam int LIMIT_W    = swrl_pkg::LIMIT_W;
    localparam int WINDOW_W   = swrl_pkg::WINDOW_W;
    localparam int WAIT_W     = swrl_pkg::WAIT_W;
    localparam int LCOUNT_W   = swrl_pkg::LCOUNT_W;
    localparam int CFG_W      = swrl_pkg::CFG_W;
    localparam int IN_DATA_W  = swrl_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = swrl_pkg::OUT_DATA_W;
    localparam logic [WAIT_W-1:0]   WAIT_MAX    = swrl_pkg::WAIT_MAX;
    localparam logic [ACTION_W-1:0] ACT_CHECK   = swrl_pkg::ACT_CHECK;
    localparam logic [ACTION_W-1:0] ACT_RECORD  = swrl_pkg::ACT_RECORD;
    localparam logic [ACTION_W-1:0] ACT_CORRECT = swrl_pkg::ACT_CORRECT;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int N_DIRECTED = 21;
    localparam int PHASE_ITEMS = 358;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   stamp;
        logic [SCOUNT_W-1:0] scount;
        logic [LIMIT_W-1:0]  slimit;
        logic [WINDOW_W-1:0] swindow;
    } t_limiter_req;

    typedef struct packed {
        logic [WAIT_W-1:0]   delay_s;
        logic [LCOUNT_W-1:0] count;
        logic                ovf;
    } t_verdict;

    typedef struct packed {
        t_limiter_req req;
        logic         typed;
        t_verdict     want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [ACTION_W-1:0]   s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [0:0]            i_cfg_addr = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;

    // local copy of the limiter state
    logic [TIME_W-1:0]   m_log [DEPTH];
    int unsigned         m_head;
    int unsigned         m_count;
    logic [LIMIT_W-1:0]  m_limit;
    logic [WINDOW_W-1:0] m_window;

    t_verdict            verdict_q [$];
    int                  mismatches = 0;
    int                  idle_pct = 0;
    int                  stall_pct = 0;
    int                  quiet_cycles = 0;
    logic [TIME_W-1:0]   wall_now = '0;

    t_dir_row directed_rows [N_DIRECTED] = '{
        '{'{ACT_CHECK,   32'd0,          32'd0,          8'd0,   8'd0,   16'd0},
          1'b1, '{17'd0, 8'd0, 1'b0}},
        '{'{ACT_RECORD,  32'd100,        32'd100,        8'd0,   8'd0,   16'd0},
          1'b1, '{17'd0, 8'd1, 1'b0}},
        // stamp in the future never expires
        '{'{ACT_RECORD,  32'd100,        32'hFFFF_FFFF,  8'd0,   8'd0,   16'd0},
          1'b1, '{17'd0, 8'd2, 1'b0}},
        '{'{ACT_CHECK,   32'hFFFF_FFFF,  32'd0,          8'd0,   8'd0,   16'd0},
          1'b0, '0},
        // unknown action acts as check, server fields ignored
        '{'{ACT_UNUSED,  32'd0,          32'h1234_5678,  8'hFF,  8'hFF,  16'hFFFF},
          1'b0, '0},
        // zero limit and window adopted, empty log gives window plus one
        '{'{ACT_CORRECT, 32'd5,          32'd0,          8'd0,   8'd0,   16'd0},
          1'b1, '{17'd1, 8'd0, 1'b0}},
        // pad past depth stops at a full log
        '{'{ACT_CORRECT, 32'd1000,       32'd0,          8'd255, 8'd255, 16'hFFFF},
          1'b1, '{17'd0, 8'd128, 1'b0}},
        '{'{ACT_RECORD,  32'd1000,       32'd1000,       8'd0,   8'd0,   16'd0},
          1'b1, '{17'd0, 8'd128, 1'b1}},
        '{'{ACT_CORRECT, 32'd1000,       32'd0,          8'd200, 8'd128, 16'hFFFF},
          1'b1, '{17'd65536, 8'd128, 1'b1}},
        '{'{ACT_CHECK,   32'd0,          32'd0,          8'd0,   8'd0,   16'd0},
          1'b0, '0},
        // window shrinks below the age of the oldest stamp, wait clamps to zero
        '{'{ACT_CORRECT, 32'd50000,      32'd0,          8'd128, 8'd1,   16'd1},
          1'b1, '{17'd0, 8'd128, 1'b0}},
        '{'{ACT_CHECK,   32'd50000,      32'd0,          8'd0,   8'd0,   16'd0},
          1'b1, '{17'd0, 8'd0, 1'b0}},
        '{'{ACT_CORRECT, 32'd0,          32'd0,          8'd0,   8'd1,   16'hFFFF},
          1'b1, '{17'd0, 8'd0, 1'b0}},
        // far future stamp saturates the wait
        '{'{ACT_RECORD,  32'd0,          32'h0010_0000,  8'd0,   8'd0,   16'd0},
          1'b1, '{WAIT_MAX, 8'd1, 1'b0}},
        '{'{ACT_RECORD,  32'd0,          32'd0,          8'd0,   8'd0,   16'd0},
          1'b0, '0},
        '{'{ACT_CHECK,   32'h0010_FFFF,  32'd0,          8'd0,   8'd0,   16'd0},
          1'b0, '0},
        '{'{ACT_CHECK,   32'h0011_0000,  32'd0,          8'd0,   8'd0,   16'd0},
          1'b0, '0},
        '{'{ACT_CORRECT, 32'd7,          32'd0,          8'd3,   8'd3,   16'd10},
          1'b1, '{17'd11, 8'd3, 1'b0}},
        '{'{ACT_CORRECT, 32'd8,          32'd0,          8'd1,   8'd2,   16'd10},
          1'b0, '0},
        '{'{ACT_RECORD,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  8'hFF,  8'hFF,  16'hFFFF},
          1'b0, '0},
        '{'{ACT_CORRECT, 32'd0,          32'd0,          8'd128, 8'd128, 16'hFFFF},
          1'b0, '0}
    };

    sliding_window_request_limiter_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // signed age of the oldest stamp, zero on an empty log
    function automatic longint oldest_age(logic [TIME_W-1:0] now);
        if (m_count == 0) return 0;
        return longint'({32'd0, now}) - longint'({32'd0, m_log[m_head]});
    endfunction

    function automatic void drop_oldest();
        if (m_count == 0) return;
        m_head = (m_head + 1) % DEPTH;
        m_count--;
    endfunction

    function automatic bit push_stamp(logic [TIME_W-1:0] t);
        bit dropped;
        dropped = 1'b0;
        if (m_count >= DEPTH) begin
            drop_oldest();
            dropped = 1'b1;
        end
        m_log[(m_head + m_count) % DEPTH] = t;
        m_count++;
        return dropped;
    endfunction

    function automatic t_verdict predict_verdict(t_limiter_req r);
        t_verdict v;
        longint   d;
        v = '0;
        while (m_count > 0 && oldest_age(r.now) > longint'({48'd0, m_window}))
            drop_oldest();
        case (r.action)
            ACT_RECORD: begin
                v.ovf = push_stamp(r.stamp);
            end
            ACT_CORRECT: begin
                m_limit  = r.slimit;
                m_window = r.swindow;
                while (m_count > r.scount)
                    drop_oldest();
                while (m_count < r.scount) begin
                    if (push_stamp(r.now)) v.ovf = 1'b1;
                    if (m_count >= DEPTH && r.scount > DEPTH) break;
                end
            end
            default: ;
        endcase
        if (m_count >= m_limit) begin
            d = longint'({48'd0, m_window}) - oldest_age(r.now) + 1;
            if (d < 0) d = 0;
            if (d > longint'({47'd0, WAIT_MAX})) d = longint'({47'd0, WAIT_MAX});
            v.delay_s = d[WAIT_W-1:0];
        end
        v.count = m_count[LCOUNT_W-1:0];
        return v;
    endfunction

    // mostly a steady clock with stamps near now, some noise words
    function automatic t_limiter_req make_request();
        t_limiter_req r;
        int unsigned  step_max;
        int unsigned  pick;
        if ($urandom_range(99) < 15) begin
            r.action  = ACTION_W'($urandom);
            r.now     = $urandom;
            r.stamp   = $urandom;
            r.scount  = SCOUNT_W'($urandom);
            r.slimit  = LIMIT_W'($urandom);
            r.swindow = WINDOW_W'($urandom);
            if ($urandom_range(1) == 1) wall_now = r.now;
            return r;
        end
        step_max = ($urandom_range(3) == 0) ? m_window / 4 + 1 : m_window / 256 + 1;
        wall_now += $urandom_range(0, step_max);
        r.now = wall_now;
        pick = $urandom_range(99);
        if (pick < 50)      r.action = ACT_RECORD;
        else if (pick < 80) r.action = ACT_CHECK;
        else if (pick < 95) r.action = ACT_CORRECT;
        else                r.action = ACT_UNUSED;
        pick = $urandom_range(9);
        if (pick == 0)      r.stamp = r.now + $urandom_range(1, 70000);
        else if (pick == 1) r.stamp = r.now - $urandom_range(0, m_window + 2);
        else                r.stamp = r.now - $urandom_range(0, 3);
        r.scount  = ($urandom_range(7) == 0) ? SCOUNT_W'($urandom)
                                             : SCOUNT_W'($urandom_range(0, 130));
        r.slimit  = ($urandom_range(7) == 0) ? LIMIT_W'($urandom)
                                             : LIMIT_W'($urandom_range(1, 128));
        r.swindow = ($urandom_range(3) == 0) ? WINDOW_W'($urandom) : m_window;
        return r;
    endfunction

    task automatic send_word(input t_limiter_req r, input logic typed, input t_verdict want);
        t_verdict v;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.action;
        s_axis_tdata  <= {r.swindow, r.slimit, r.scount, r.stamp, r.now};
        do @(posedge i_clk); while (!s_axis_tready);
        v = predict_verdict(r);
        verdict_q.insert(verdict_q.size(), typed ? want : v);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        if (idx == swrl_pkg::REG_INIT_LIMIT) m_limit = val[LIMIT_W-1:0];
        else                                 m_window = val[WINDOW_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (verdict_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic check_verdict();
        t_verdict want;
        t_verdict got;
        got.delay_s = m_axis_tdata[WAIT_W-1:0];
        got.count   = m_axis_tdata[WAIT_W+LCOUNT_W-1:WAIT_W];
        got.ovf     = m_axis_tuser[0];
        if (verdict_q.size() == 0) begin
            if (mismatches < REPORT_MAX)
                $display("unexpected word: wait %0d count %0d ovf %0d",
                         got.delay_s, got.count, got.ovf);
            mismatches++;
            return;
        end
        want = verdict_q.pop_front();
        if (got.delay_s !== want.delay_s || got.count !== want.count
                || got.ovf !== want.ovf) begin
            if (mismatches < REPORT_MAX)
                $display("mismatch: wait %0d/%0d count %0d/%0d ovf %0d/%0d (exp/act)",
                         want.delay_s, got.delay_s, want.count, got.count,
                         want.ovf, got.ovf);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_verdict();
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        m_head   = 0;
        m_count  = 0;
        m_limit  = swrl_pkg::LIMIT_RST;
        m_window = swrl_pkg::WINDOW_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_word(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        s_axis_tvalid <= 1'b0;

        // phases: free flow, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_cfg(swrl_pkg::REG_INIT_LIMIT, 16'd8);
                    write_cfg(swrl_pkg::REG_INIT_WINDOW, 16'd30);
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    write_cfg(swrl_pkg::REG_INIT_LIMIT, 16'd128);
                    write_cfg(swrl_pkg::REG_INIT_WINDOW, 16'hFFFF);
                    idle_pct  = 60;
                    stall_pct = 0;
                end
                2: begin
                    write_cfg(swrl_pkg::REG_INIT_LIMIT, 16'd1);
                    write_cfg(swrl_pkg::REG_INIT_WINDOW, 16'd1);
                    idle_pct  = 0;
                    stall_pct = 60;
                end
                default: begin
                    write_cfg(swrl_pkg::REG_INIT_LIMIT, CFG_W'($urandom_range(1, 128)));
                    write_cfg(swrl_pkg::REG_INIT_WINDOW, CFG_W'($urandom_range(1, 65535)));
                    idle_pct  = 21;
                    stall_pct = 21;
                end
            endcase
            wall_now = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_word(make_request(), 1'b0, '0);
            s_axis_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
